@@ rtl/led_blink_priority_engine_defines.svh @@
// assertion macros shared by the led blink priority engine rtl
// expects clk and arst_n in the scope of each use
`ifndef LED_BLINK_PRIORITY_ENGINE_DEFINES_SVH
`define LED_BLINK_PRIORITY_ENGINE_DEFINES_SVH

// condition that must hold at every clock edge out of reset
`define LBPE_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// condition that must hold in the cycle after a trigger
`define LBPE_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

@@ rtl/lbpe_pkg.sv @@
// package for the led blink priority engine: constants, microcode word type and program rom
// no dependencies
package lbpe_pkg;

	localparam int RULE_COUNT_DEF   = 8;
	localparam int LED_COUNT_DEF    = 3;
	localparam int LED_BASE_PIN_DEF = 4;

	localparam int RULE_W    = 24;
	localparam int FLAGS_W   = 16;
	localparam int PIN_W     = 3;
	localparam int PHASE_W   = 7;
	localparam int PERIOD_W  = 8;
	localparam int FRAC_W    = 5;
	localparam int PROD_W    = PERIOD_W + FRAC_W;
	localparam int CFG_IDX_W = 3;

	localparam logic [PHASE_W-1:0] PHASE_WRAP = 7'd100;
	// x / 20 == ((x >> 2) * 13108) >> 16, exact for x below 2^13
	localparam logic [13:0] RECIP_FIFTH = 14'd13108;

	// default code meaning no forced level
	localparam logic [1:0] DFLT_NONE = 2'd0;

	// microcode ops
	localparam logic [1:0] OP_WAIT  = 2'd0;
	localparam logic [1:0] OP_LOAD  = 2'd1;
	localparam logic [1:0] OP_EVAL  = 2'd2;
	localparam logic [1:0] OP_FLUSH = 2'd3;

	// jump conditions
	localparam logic [1:0] COND_NEXT  = 2'd0;
	localparam logic [1:0] COND_INPUT = 2'd1;
	localparam logic [1:0] COND_MORE  = 2'd2;
	localparam logic [1:0] COND_JUMP  = 2'd3;

	// program addresses
	localparam logic [1:0] STEP_WAIT  = 2'd0;
	localparam logic [1:0] STEP_LOAD  = 2'd1;
	localparam logic [1:0] STEP_EVAL  = 2'd2;
	localparam logic [1:0] STEP_FLUSH = 2'd3;

	typedef struct packed {
		logic [1:0] op;
		logic [1:0] cond;
		logic [1:0] target;
	} uword_t;

	function automatic uword_t ucode(input logic [1:0] step);
		uword_t w;
		case (step)
			STEP_WAIT:  w = '{op: OP_WAIT,  cond: COND_INPUT, target: STEP_LOAD};
			STEP_LOAD:  w = '{op: OP_LOAD,  cond: COND_NEXT,  target: STEP_EVAL};
			STEP_EVAL:  w = '{op: OP_EVAL,  cond: COND_MORE,  target: STEP_LOAD};
			STEP_FLUSH: w = '{op: OP_FLUSH, cond: COND_JUMP,  target: STEP_WAIT};
			default:    w = '{op: OP_WAIT,  cond: COND_JUMP,  target: STEP_WAIT};
		endcase
		return w;
	endfunction

endpackage

@@ rtl/led_blink_priority_engine.sv @@
// led blink priority engine top level: microcoded rule scanner with output register
// depends on lbpe_pkg and led_blink_priority_engine_defines.svh
//
// channel   dir  handshake              payload
// s_*       in   s_tvalid / s_tready    s_tdata[15:0] status_flags
// m_*       out  m_tvalid / m_tready    m_tdata[2:0] write_pin, [3] write_level, m_tlast
// cfg_*     in   cfg_valid / cfg_ready  cfg_index rule number, cfg_data rule word
//
// a tick is an accept step, a load and an evaluate step per rule word, and a flush
// step that marks the final write; the product of period and fraction is registered
// by the load step, before the reciprocal multiply that divides it by twenty
// a write that must push the pending one into a full output register holds the sequencer
// until it drains
// reset clears rules, phase, led records and the sequencer; cfg_ready is always high
`include "led_blink_priority_engine_defines.svh"

module led_blink_priority_engine #(
	parameter int RULE_COUNT   = lbpe_pkg::RULE_COUNT_DEF,
	parameter int LED_COUNT    = lbpe_pkg::LED_COUNT_DEF,
	parameter int LED_BASE_PIN = lbpe_pkg::LED_BASE_PIN_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [lbpe_pkg::FLAGS_W-1:0]    s_tdata,   // status_flags
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [7:0]                      m_tdata,   // write_pin[2:0], write_level[3], zeros
	output logic                            m_tlast,   // last_write
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lbpe_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lbpe_pkg::RULE_W-1:0]     cfg_data
);
	import lbpe_pkg::*;

	localparam int RIDX_W = (RULE_COUNT > 1) ? $clog2(RULE_COUNT) : 1;
	localparam int LIDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
	localparam int NPINS  = 1 << PIN_W;

	// rule words and per-led records {state, phase stamp}
	logic [RULE_W-1:0]    rules_q [RULE_COUNT];
	logic [PHASE_W:0]     record_q [LED_COUNT];

	// sequencer
	logic [1:0]           step_q;
	logic [RIDX_W-1:0]    rule_q;
	uword_t               uw;
	logic                 more_rules;
	logic                 stall;

	logic [PHASE_W-1:0]   phase_q;
	logic [FLAGS_W-1:0]   flags_q;
	logic [NPINS-1:0]     claimed_q;

	// fields latched by the load step
	logic [PIN_W-1:0]     pin_q;
	logic [LIDX_W-1:0]    lidx_q;
	logic [1:0]           dcode_q;
	logic                 inv_q;
	logic                 active_q;
	logic                 skip_q;
	logic [PERIOD_W-1:0]  period_q;
	logic [PROD_W-1:0]    product_q;
	logic [PHASE_W-1:0]   stamp_q;
	logic                 is_on_q;

	// pending write, held until we know whether another follows
	logic                 pend_valid_q;
	logic [PIN_W-1:0]     pend_pin_q;
	logic                 pend_level_q;

	// output register
	logic                 out_valid_q;
	logic [PIN_W-1:0]     out_pin_q;
	logic                 out_level_q;
	logic                 out_last_q;
	logic                 out_free;

	// load step decode
	logic [RULE_W-1:0]    word;
	logic [PIN_W-1:0]     w_pin;
	logic [PIN_W:0]       pin_diff;
	logic                 pin_ok;
	logic [LIDX_W-1:0]    w_lidx;
	logic [3:0]           w_fidx;
	logic [PHASE_W:0]     rec_rd;

	// evaluate step
	logic [24:0]          quot_full;
	logic [PERIOD_W-1:0]  t_off;
	logic [PERIOD_W-1:0]  t_on;
	logic [PERIOD_W-1:0]  elapsed;
	logic                 wrap;
	logic                 target;
	logic                 emit;
	logic                 emit_state;
	logic                 claim;

	logic                 in_acc;
	logic                 tick_end;

	assign uw         = ucode(step_q);
	assign s_tready   = (uw.op == OP_WAIT);
	assign in_acc     = s_tvalid && s_tready;
	assign cfg_ready  = 1'b1;
	assign out_free   = !out_valid_q || m_tready;
	assign more_rules = (rule_q != RIDX_W'(RULE_COUNT - 1));

	// rule word decode
	assign word     = rules_q[rule_q];
	assign w_pin    = word[15:13];
	assign pin_diff = {1'b0, w_pin} - (PIN_W+1)'(LED_BASE_PIN);
	assign pin_ok   = (w_pin >= PIN_W'(LED_BASE_PIN)) && (pin_diff < (PIN_W+1)'(LED_COUNT));
	assign w_lidx   = pin_diff[LIDX_W-1:0];
	assign w_fidx   = word[23:20];
	assign rec_rd   = pin_ok ? record_q[w_lidx] : '0;

	// timing: t_off = period * frac / 20, t_on = period - t_off, both mod 256
	assign quot_full = product_q[PROD_W-1:2] * RECIP_FIFTH;
	assign t_off     = quot_full[16 +: PERIOD_W];
	assign t_on      = period_q - t_off;
	assign elapsed   = {1'b0, phase_q} - {1'b0, stamp_q};
	assign wrap      = (phase_q < stamp_q);
	assign target    = (dcode_q[1]) ^ inv_q;

	always_comb begin
		emit       = 1'b0;
		emit_state = 1'b0;
		claim      = 1'b0;
		if (!skip_q) begin
			if (!active_q) begin
				// inactive rule: optional default level, never claims
				if ((dcode_q != DFLT_NONE) && (is_on_q != target)) begin
					emit       = 1'b1;
					emit_state = target;
				end
			end else begin
				claim = 1'b1;
				if ((stamp_q == '0) || (t_off == '0)) begin
					emit       = 1'b1;
					emit_state = 1'b1;
				end else if (is_on_q && ((elapsed >= t_on) || wrap)) begin
					emit       = 1'b1;
					emit_state = 1'b0;
				end else if (!is_on_q && ((elapsed >= t_off) || wrap)) begin
					emit       = 1'b1;
					emit_state = 1'b1;
				end
			end
		end
	end

	// a write that must push the pending one out waits for a free output slot
	assign stall = pend_valid_q && !out_free &&
		(((uw.op == OP_EVAL) && emit) || (uw.op == OP_FLUSH));
	assign tick_end = (uw.op == OP_FLUSH) && !stall;

	// sequencer: step counter with conditional jumps from the control word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_WAIT;
			rule_q <= '0;
		end else if (!stall) begin
			case (uw.cond)
				COND_NEXT:  step_q <= step_q + 2'd1;
				COND_INPUT: step_q <= in_acc ? uw.target : step_q;
				COND_MORE:  step_q <= more_rules ? uw.target : step_q + 2'd1;
				COND_JUMP:  step_q <= uw.target;
				default:    step_q <= STEP_WAIT;
			endcase
			if (in_acc) begin
				rule_q <= '0;
			end else if ((uw.op == OP_EVAL) && more_rules) begin
				rule_q <= rule_q + RIDX_W'(1);
			end
		end
	end

	// configuration writes; indexes past the rule count are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RULE_COUNT; i++) begin
				rules_q[i] <= '0;
			end
		end else if (cfg_valid && cfg_ready &&
				({1'b0, cfg_index} < (CFG_IDX_W+1)'(RULE_COUNT))) begin
			rules_q[cfg_index[RIDX_W-1:0]] <= cfg_data;
		end
	end

	// tick state: phase, claims, led records
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= '0;
			claimed_q <= '0;
			for (int i = 0; i < LED_COUNT; i++) begin
				record_q[i] <= '0;
			end
		end else if (in_acc) begin
			phase_q   <= (phase_q == PHASE_WRAP - 7'd1) ? '0 : phase_q + 7'd1;
			claimed_q <= '0;
		end else if ((uw.op == OP_EVAL) && !stall) begin
			if (claim) begin
				claimed_q[pin_q] <= 1'b1;
			end
			if (emit) begin
				record_q[lidx_q] <= {emit_state, phase_q};
			end
		end
	end

	// load step latches the rule, its record and the period product
	always_ff @(posedge clk) begin
		if (in_acc) begin
			flags_q <= s_tdata;
		end
		if (uw.op == OP_LOAD) begin
			pin_q     <= w_pin;
			lidx_q    <= w_lidx;
			dcode_q   <= word[17:16];
			inv_q     <= word[18];
			active_q  <= flags_q[w_fidx] ^ word[19];
			skip_q    <= !pin_ok || claimed_q[w_pin];
			period_q  <= word[7:0];
			product_q <= word[7:0] * word[12:8];
			stamp_q   <= rec_rd[PHASE_W-1:0];
			is_on_q   <= rec_rd[PHASE_W];
		end
	end

	// pending write and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if ((uw.op == OP_EVAL) && emit && !stall) begin
				pend_valid_q <= 1'b1;
				if (pend_valid_q) begin
					out_valid_q <= 1'b1;
				end
			end else if (tick_end) begin
				pend_valid_q <= 1'b0;
				if (pend_valid_q) begin
					out_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((uw.op == OP_EVAL) && emit && !stall) begin
			pend_pin_q   <= pin_q;
			pend_level_q <= emit_state ^ inv_q ^ 1'b1;
			if (pend_valid_q) begin
				out_pin_q   <= pend_pin_q;
				out_level_q <= pend_level_q;
				out_last_q  <= 1'b0;
			end
		end else if (tick_end && pend_valid_q) begin
			out_pin_q   <= pend_pin_q;
			out_level_q <= pend_level_q;
			out_last_q  <= 1'b1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, out_level_q, out_pin_q};
	assign m_tlast  = out_last_q;

	`LBPE_ASSERT_ALWAYS(a_phase_range, phase_q < PHASE_WRAP, "phase counter out of range")
	`LBPE_ASSERT_ALWAYS(a_idle_no_pending, (step_q != STEP_WAIT) || !pend_valid_q,
		"pending write left over at tick end")
	`LBPE_ASSERT_NEXT(a_accept_starts_scan, in_acc,
		(step_q == STEP_LOAD) && (rule_q == '0), "tick did not start at first rule")
	`LBPE_ASSERT_NEXT(a_flush_marks_last, (uw.op == OP_FLUSH) && pend_valid_q && out_free,
		m_tvalid && m_tlast, "final write of a tick not marked last")

endmodule

@@ verif/led_blink_priority_engine_tb.sv @@
// self-checking testbench for the led blink priority engine: directed table, then random ticks
// depends on lbpe_pkg and the led_blink_priority_engine rtl
module led_blink_priority_engine_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RULE_N          = lbpe_pkg::RULE_COUNT_DEF;
	localparam int LED_N           = lbpe_pkg::LED_COUNT_DEF;
	localparam int LED_BASE        = lbpe_pkg::LED_BASE_PIN_DEF;
	localparam int RULE_W          = lbpe_pkg::RULE_W;
	localparam int FLAGS_W         = lbpe_pkg::FLAGS_W;
	localparam int TWENTIETHS      = 20;
	// room for the accept, load, evaluate and flush steps of two ticks, plus the output register and some margin
	localparam int DRAIN_CYCLES    = 2 * (2 + 2 * RULE_N) + 8;
	localparam int LONG_HOLD       = 400;
	localparam int RUN_PHASES      = 10;
	localparam int TICKS_PER_PHASE = 25;
	localparam int MAX_PHASE       = 3;    // every rule word at its top value but for a random pin
	localparam int MIN_PHASE       = 7;    // every rule word empty but for a random pin
	localparam int PRESSURE_PHASE  = 2;
	localparam int BURST_PHASE     = 4;
	localparam int CYCLE_LIMIT     = 600000;
	localparam int DIR_ROWS        = 27;

	// default levels an inactive rule may force
	typedef enum logic [1:0] {
		DFLT_NONE   = 2'd0,
		DFLT_OFF    = 2'd1,
		DFLT_ON     = 2'd2,
		DFLT_ON_ALT = 2'd3
	} dflt_code_t;

	typedef enum logic {
		ROW_CFG  = 1'b0,
		ROW_TICK = 1'b1
	} row_kind_t;

	typedef struct packed {
		logic [2:0] pin;
		logic       level;
		logic       last;
	} pin_write_t;

	// one row of the directed table; fixed rows carry their result typed in
	typedef struct {
		row_kind_t          kind;
		logic [2:0]         reg_idx;
		logic [RULE_W-1:0]  word;
		logic [FLAGS_W-1:0] flags;
		bit                 fixed;
		int                 fx_cnt;
		logic [2:0]         fx_pin;
		logic               fx_level;
	} stim_row_t;

	// rule word: [23:20] flag index, [19] flag polarity, [18] inverted, [17:16] default,
	// [15:13] pin, [12:8] off twentieths, [7:0] period
	stim_row_t dir_rows [DIR_ROWS] = '{
		'{ROW_TICK, 3'd0, 24'h000000, 16'h0000, 1'b1, 0, 3'd0, 1'b0}, // reset rules sit on pin 0
		'{ROW_TICK, 3'd0, 24'h000000, 16'hFFFF, 1'b1, 0, 3'd0, 1'b0}, // active but pin out of range
		'{ROW_CFG,  3'd0, 24'h00800A, 16'h0000, 1'b0, 0, 3'd0, 1'b0}, // pin 4, no off time
		'{ROW_TICK, 3'd0, 24'h000000, 16'h0001, 1'b1, 1, 3'd4, 1'b0}, // forced on, active low
		'{ROW_TICK, 3'd0, 24'h000000, 16'h0000, 1'b1, 0, 3'd0, 1'b0}, // inactive, no default
		'{ROW_CFG,  3'd1, 24'hF5BFFF, 16'h0000, 1'b0, 0, 3'd0, 1'b0}, // pin 5, fraction 31, flag 15
		'{ROW_TICK, 3'd0, 24'h000000, 16'h7FFF, 1'b0, 0, 3'd0, 1'b0}, // default off, inverted
		'{ROW_TICK, 3'd0, 24'h000000, 16'h8000, 1'b0, 0, 3'd0, 1'b0}, // fraction above twenty
		'{ROW_CFG,  3'd2, 24'h0A8A04, 16'h0000, 1'b0, 0, 3'd0, 1'b0}, // pin 4 again, flag clear
		'{ROW_TICK, 3'd0, 24'h000000, 16'h0001, 1'b0, 0, 3'd0, 1'b0}, // pin already claimed
		'{ROW_TICK, 3'd0, 24'h000000, 16'h0000, 1'b0, 0, 3'd0, 1'b0},
		'{ROW_TICK, 3'd0, 24'h000000, 16'h0000, 1'b0, 0, 3'd0, 1'b0},
		'{ROW_CFG,  3'd3, 24'h02E00A, 16'h0000, 1'b0, 0, 3'd0, 1'b0}, // pin 7, above the leds
		'{ROW_CFG,  3'd4, 24'h036005, 16'h0000, 1'b0, 0, 3'd0, 1'b0}, // pin 3, below the leds
		'{ROW_CFG,  3'd5, 24'h23C514, 16'h0000, 1'b0, 0, 3'd0, 1'b0}, // pin 6, default code 3
		'{ROW_CFG,  3'd6, 24'hFFFFFF, 16'h0000, 1'b0, 0, 3'd0, 1'b0}, // all ones lands on pin 7
		'{ROW_CFG,  3'd7, 24'h16CF08, 16'h0000, 1'b0, 0, 3'd0, 1'b0}, // pin 6, default on, inv
		'{ROW_TICK, 3'd0, 24'h000000, 16'h0000, 1'b0, 0, 3'd0, 1'b0},
		'{ROW_TICK, 3'd0, 24'h000000, 16'h0004, 1'b0, 0, 3'd0, 1'b0},
		'{ROW_TICK, 3'd0, 24'h000000, 16'h0006, 1'b0, 0, 3'd0, 1'b0},
		'{ROW_TICK, 3'd0, 24'h000000, 16'hFFFF, 1'b0, 0, 3'd0, 1'b0},
		'{ROW_TICK, 3'd0, 24'h000000, 16'h0002, 1'b0, 0, 3'd0, 1'b0},
		'{ROW_TICK, 3'd0, 24'h000000, 16'h0000, 1'b0, 0, 3'd0, 1'b0}, // all flags clear
		'{ROW_TICK, 3'd0, 24'h000000, 16'hAAAA, 1'b0, 0, 3'd0, 1'b0},
		'{ROW_TICK, 3'd0, 24'h000000, 16'h5555, 1'b0, 0, 3'd0, 1'b0},
		'{ROW_TICK, 3'd0, 24'h000000, 16'h8001, 1'b0, 0, 3'd0, 1'b0},
		'{ROW_TICK, 3'd0, 24'h000000, 16'h0000, 1'b0, 0, 3'd0, 1'b0}
	};

	logic                             clk;
	logic                             arst_n;
	logic                             s_tvalid;
	logic                             s_tready;
	logic [FLAGS_W-1:0]               s_tdata;    // status_flags
	logic                             m_tvalid;
	logic                             m_tready;
	logic [7:0]                       m_tdata;    // write_pin[2:0], write_level[3], zeros
	logic                             m_tlast;    // last_write
	logic                             cfg_valid;
	logic                             cfg_ready;
	logic [lbpe_pkg::CFG_IDX_W-1:0]   cfg_index;
	logic [RULE_W-1:0]                cfg_data;

	// shadow of the engine: rule words, tick phase and the per-led record
	logic [RULE_W-1:0] rule_copy [RULE_N];
	logic [6:0]        phase_now;
	logic              led_on    [LED_N];
	logic [6:0]        led_stamp [LED_N];

	pin_write_t writes_due [$];   // pin writes predicted and not yet seen, oldest first
	int         fail_count;
	int         cycle_count;
	bit         tx_burst;         // sender offers items back to back
	bit         rx_burst;         // receiver never holds off
	bit         hold_req;         // asks the receiver for one long hold-off

	led_blink_priority_engine i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// one tick of the blink engine: returns how many pin writes it queued
	function automatic int predict_tick(input logic [FLAGS_W-1:0] flags);
		logic [RULE_W-1:0] rw;
		logic [7:0]        period;
		logic [7:0]        t_off;
		logic [7:0]        t_on;
		logic [7:0]        elapsed;
		logic [4:0]        frac;
		logic [2:0]        pin;
		logic [1:0]        dcode;
		logic [3:0]        fidx;
		logic [6:0]        stamp;
		logic [7:0]        claimed;
		logic              inv;
		logic              fpol;
		logic              is_on;
		logic              wrap;
		logic              new_state;
		logic              do_write;
		logic              have_held;
		pin_write_t        held;
		int                idx;
		int                n;
		claimed   = '0;
		have_held = 1'b0;
		held      = '0;
		n         = 0;
		phase_now = (phase_now + 7'd1 >= lbpe_pkg::PHASE_WRAP) ? 7'd0 : phase_now + 7'd1;
		for (int r = 0; r < RULE_N; r++) begin
			rw = rule_copy[r];
			{fidx, fpol, inv, dcode, pin, frac, period} = rw;
			idx       = int'(pin) - LED_BASE;
			do_write  = 1'b0;
			new_state = 1'b0;
			// rules off the led pins and pins taken earlier this tick do nothing
			if (idx >= 0 && idx < LED_N && !claimed[pin]) begin
				stamp = led_stamp[idx];
				is_on = led_on[idx];
				if (!(flags[fidx] ^ fpol)) begin
					// inactive: maybe force the default level, never claims the pin
					if (dcode != DFLT_NONE) begin
						new_state = (dcode >= DFLT_ON) ^ inv;
						do_write  = (is_on != new_state);
					end
				end else begin
					claimed[pin] = 1'b1;
					t_off   = 8'((int'(period) * int'(frac)) / TWENTIETHS);
					t_on    = period - t_off;
					wrap    = phase_now < stamp;
					elapsed = {1'b0, phase_now} - {1'b0, stamp};
					if (stamp == '0 || t_off == '0) begin
						do_write  = 1'b1;
						new_state = 1'b1;
					end else if (is_on && (elapsed >= t_on || wrap)) begin
						do_write  = 1'b1;
						new_state = 1'b0;
					end else if (!is_on && (elapsed >= t_off || wrap)) begin
						do_write  = 1'b1;
						new_state = 1'b1;
					end
				end
			end
			// hold back the newest write so the final one can get its last mark
			if (do_write) begin
				if (have_held) begin
					writes_due.push_back(held);
					n++;
				end
				held           = '{pin: pin, level: new_state ^ inv ^ 1'b1, last: 1'b0};
				have_held      = 1'b1;
				led_on[idx]    = new_state;
				led_stamp[idx] = phase_now;
			end
		end
		if (have_held) begin
			held.last = 1'b1;
			writes_due.push_back(held);
			n++;
		end
		return n;
	endfunction

	// idle lengths: mostly none, some short, a few long
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		else if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// random rule word, biased toward led pins, low flag indexes and short periods
	function automatic logic [RULE_W-1:0] pick_rule(input int phase_no);
		logic [2:0] pin;
		logic [4:0] frac;
		logic [7:0] period;
		logic [3:0] fidx;
		int         roll;
		if ($urandom_range(0, 9) < 8)
			pin = 3'(LED_BASE + $urandom_range(0, LED_N - 1));
		else
			pin = 3'($urandom_range(0, 7));
		if (phase_no == MAX_PHASE)
			return {8'hFF, pin, 13'h1FFF};
		if (phase_no == MIN_PHASE)
			return {8'h00, pin, 13'h0000};
		roll = $urandom_range(0, 99);
		if (roll < 80)
			frac = 5'($urandom_range(1, 19));
		else if (roll < 90)
			frac = 5'd0;
		else
			frac = 5'($urandom_range(20, 31));
		roll = $urandom_range(0, 99);
		if (roll < 60)
			period = 8'($urandom_range(1, 30));
		else if (roll < 90)
			period = 8'($urandom_range(31, 120));
		else
			period = 8'($urandom_range(0, 255));
		fidx = ($urandom_range(0, 3) != 0) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
		return {fidx, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			2'($urandom_range(0, 3)), pin, frac, period};
	endfunction

	function automatic void log_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("mismatch: %s", msg);
	endfunction

	// offer one tick until taken, then predict its writes
	task automatic send_tick(input logic [FLAGS_W-1:0] flags, output int n_new);
		s_tvalid <= 1'b1;
		s_tdata  <= flags;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		n_new = predict_tick(flags);
	endtask

	task automatic sender_pause();
		int g;
		g = tx_burst ? 0 : pick_gap();
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// leaves cfg_valid high; the caller drops it after the last write of a batch
	task automatic write_rule(input logic [2:0] idx, input logic [RULE_W-1:0] word);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= word;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		rule_copy[idx] = word;
	endtask

	// stop offering ticks, wait for every predicted write, then wait out the drain time
	task automatic settle();
		s_tvalid <= 1'b0;
		while (writes_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// receiver: checks each accepted write, idles at random, one long hold-off on request
	initial begin
		pin_write_t due;
		int         hold_left;
		hold_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				if (writes_due.size() == 0) begin
					log_failure($sformatf("pin write with none due: tdata %h tlast %b",
						m_tdata, m_tlast));
				end else begin
					due = writes_due.pop_front();
					if (m_tdata[2:0] !== due.pin || m_tdata[3] !== due.level ||
							m_tdata[7:4] !== 4'd0 || m_tlast !== due.last)
						log_failure($sformatf(
							"expected pin %0d level %b last %b, got pin %0d level %b pad %h last %b",
							due.pin, due.level, due.last, m_tdata[2:0], m_tdata[3],
							m_tdata[7:4], m_tlast));
				end
			end
			if (hold_left == 0 && hold_req) begin
				hold_left = LONG_HOLD;
				hold_req  = 1'b0;
			end else if (hold_left == 0 && !rx_burst && $urandom_range(0, 3) == 0) begin
				hold_left = pick_gap();
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		logic [FLAGS_W-1:0] base_flags;
		logic [FLAGS_W-1:0] flags;
		pin_write_t         typed_write;
		int                 n_new;
		int                 roll;
		fail_count = 0;
		tx_burst   = 1'b0;
		rx_burst   = 1'b0;
		hold_req   = 1'b0;
		phase_now  = '0;
		for (int r = 0; r < RULE_N; r++)
			rule_copy[r] = '0;
		for (int i = 0; i < LED_N; i++) begin
			led_on[i]    = 1'b0;
			led_stamp[i] = '0;
		end
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: rule writes wait for the engine to go idle
		for (int i = 0; i < DIR_ROWS; i++) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				settle();
				write_rule(dir_rows[i].reg_idx, dir_rows[i].word);
				cfg_valid <= 1'b0;
			end else begin
				send_tick(dir_rows[i].flags, n_new);
				// typed rows replace what the shadow just queued, its state still advances
				if (dir_rows[i].fixed) begin
					repeat (n_new) void'(writes_due.pop_back());
					if (dir_rows[i].fx_cnt == 1) begin
						typed_write = '{pin: dir_rows[i].fx_pin, level: dir_rows[i].fx_level,
							last: 1'b1};
						writes_due.push_back(typed_write);
					end
				end
				sender_pause();
			end
		end

		// random phases: fresh rule set, then ticks on a mostly steady flag pattern
		for (int p = 0; p < RUN_PHASES; p++) begin
			settle();
			for (int r = 0; r < RULE_N; r++)
				write_rule(3'(r), pick_rule(p));
			cfg_valid <= 1'b0;
			tx_burst = (p == BURST_PHASE || p == PRESSURE_PHASE);
			rx_burst = (p == BURST_PHASE);
			// receiver stalls long while the sender keeps offering, so the engine backs up
			if (p == PRESSURE_PHASE)
				hold_req = 1'b1;
			base_flags = 16'($urandom_range(0, 16'hFFFF));
			for (int k = 0; k < TICKS_PER_PHASE; k++) begin
				roll = $urandom_range(0, 19);
				if (roll == 0)
					base_flags = base_flags ^ (16'd1 << $urandom_range(0, 15));
				if (roll < 14)
					flags = base_flags;
				else if (roll < 18)
					flags = base_flags ^ (16'd1 << $urandom_range(0, 15));
				else
					flags = 16'($urandom_range(0, 16'hFFFF));
				send_tick(flags, n_new);
				sender_pause();
			end
		end
		tx_burst = 1'b0;
		rx_burst = 1'b0;

		settle();
		if (fail_count == 0 && writes_due.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/lbpe_pkg.sv
rtl/led_blink_priority_engine.sv
verif/led_blink_priority_engine_tb.sv
